>>> hdl/bounded_message_ring_queue_defines.svh
// Assertion macros shared by the message ring queue RTL.
// Depends on clk and rst_n being in scope where a macro is used.
`ifndef BOUNDED_MESSAGE_RING_QUEUE_DEFINES_SVH
`define BOUNDED_MESSAGE_RING_QUEUE_DEFINES_SVH

// Whenever the antecedent holds in a cycle, the consequent holds in the same cycle.
`define BMRQ_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bmrq check failed");

// Whenever the antecedent holds in a cycle, the consequent holds in the next cycle.
`define BMRQ_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bmrq check failed");

// The condition never holds.
`define BMRQ_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bmrq check failed");

`endif

>>> hdl/bmrq_pkg.sv
// Types, constants and codes for the message ring queue.
// No dependencies; used by bmrq_store and bounded_message_ring_queue.
`default_nettype none

package bmrq_pkg;

    localparam int RING_SLOTS  = 16;
    localparam int MAX_PAYLOAD = 64;
    localparam int MIN_PAYLOAD = 2;

    localparam int SLOT_W     = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int BYTE_IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int BYTE_AW    = SLOT_W + BYTE_IDX_W;
    localparam int CNT_W      = 5;
    localparam int LEN_W      = 7;
    localparam int BID_W      = 64;
    localparam int DROP_W     = 32;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};
    localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

    typedef enum logic [2:0] {
        ST_PUSHED   = 3'd0,
        ST_OVERSIZE = 3'd1,
        ST_SHORT    = 3'd2,
        ST_FULL     = 3'd3,
        ST_POPPED   = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_LIMIT    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_DESC,
        S_POP_EMIT
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [BID_W-1:0] bid;
    } desc_t;

    typedef struct packed {
        logic               we;
        logic [BYTE_AW-1:0] addr;
        logic [7:0]         data;
    } byte_wr_t;

    typedef struct packed {
        logic               re;
        logic [BYTE_AW-1:0] addr;
    } byte_rd_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        desc_t             data;
    } desc_wr_t;

    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] addr;
    } desc_rd_t;

endpackage

`default_nettype wire

>>> hdl/bmrq_store.sv
// Slot storage: payload byte memory and per-slot descriptor memory (length, bid).
// Depends on bmrq_pkg; both memories have registered reads.
`default_nettype none

module bmrq_store
    import bmrq_pkg::*;
(
    input  wire logic     clk,
    input  wire byte_wr_t byte_wr,
    input  wire byte_rd_t byte_rd,
    output logic [7:0]    byte_rdata,
    input  wire desc_wr_t desc_wr,
    input  wire desc_rd_t desc_rd,
    output desc_t         desc_rdata
);

    logic [7:0] byte_mem [RING_SLOTS*MAX_PAYLOAD];
    desc_t      desc_mem [RING_SLOTS];

    logic [7:0] byte_rdata_reg;
    desc_t      desc_rdata_reg;

    // Read data holds while no read is issued, so a stalled consumer keeps its byte.
    always_ff @(posedge clk)
    begin
        if (byte_wr.we)
        begin
            byte_mem[byte_wr.addr] <= byte_wr.data;
        end
        if (byte_rd.re)
        begin
            byte_rdata_reg <= byte_mem[byte_rd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_wr.we)
        begin
            desc_mem[desc_wr.addr] <= desc_wr.data;
        end
        if (desc_rd.re)
        begin
            desc_rdata_reg <= desc_mem[desc_rd.addr];
        end
    end

    assign byte_rdata = byte_rdata_reg;
    assign desc_rdata = desc_rdata_reg;

endmodule

`default_nettype wire

>>> hdl/bounded_message_ring_queue.sv
// Message ring queue top level: control sequencer, config registers, drop counters.
// Depends on bmrq_pkg, bmrq_store and bounded_message_ring_queue_defines.svh.
//
//   Channel   Handshake          Carries
//   ------    ---------------    ---------------------------------------------------
//   input     in_valid/ready     func, data_byte, last_byte, bid_amount
//   output    out_valid/ready    status, out_byte, out_bid, out_last, occupancy, drops
//   config    APB psel/penable   ring_capacity at 0x0, payload_limit at 0x4
//
// A push byte is handled on accept; a last byte loads its status into the output register.
// A pop of a message of N bytes passes through the accept, the descriptor memory read,
// then one byte per cycle from the byte memory's read port while the output register is free.
// An empty pop loads an empty status. Input is taken only when the sequencer is idle and the
// output register is empty or being drained. Reset is asynchronous and needs no
// clearing pass; slots are only read after they were written.
`default_nettype none
`include "bounded_message_ring_queue_defines.svh"

module bounded_message_ring_queue
    import bmrq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               func,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire logic [BID_W-1:0]   bid_amount,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0]              status,
    output logic [7:0]              out_byte,
    output logic [BID_W-1:0]        out_bid,
    output logic                    out_last,
    output logic [CNT_W-1:0]        occupancy,
    output logic [DROP_W-1:0]       full_drops,
    output logic [DROP_W-1:0]       oversize_drops,
    output logic [DROP_W-1:0]       short_drops,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cap_reg;
    logic [LEN_W-1:0]    lim_reg;
    logic [SLOT_W-1:0]   read_index_reg, read_index_next;
    logic [SLOT_W-1:0]   write_index_reg, write_index_next;
    logic [CNT_W-1:0]    held_count_reg, held_count_next;
    logic [LEN_W-1:0]    inc_len_reg, inc_len_next;
    logic                blocked_reg, blocked_next;
    logic [DROP_W-1:0]   full_cnt_reg, full_cnt_next;
    logic [DROP_W-1:0]   over_cnt_reg, over_cnt_next;
    logic [DROP_W-1:0]   short_cnt_reg, short_cnt_next;

    logic [SLOT_W-1:0]   pop_slot_reg, pop_slot_next;
    logic [LEN_W-1:0]    pop_len_reg, pop_len_next;
    logic [BID_W-1:0]    pop_bid_reg, pop_bid_next;
    logic [LEN_W-1:0]    k_reg, k_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic [BID_W-1:0]    out_bid_reg, out_bid_next;
    logic                out_last_reg, out_last_next;

    logic                cfg_write;
    logic                out_free;
    logic                in_xfer;
    logic [CNT_W-1:0]    eff_cap;
    logic [LEN_W-1:0]    eff_lim;
    logic                full_now;
    logic [LEN_W-1:0]    new_len;
    logic [LEN_W-1:0]    desc_len;
    logic [LEN_W-1:0]    k_plus;

    byte_wr_t            byte_wr;
    byte_rd_t            byte_rd;
    desc_wr_t            desc_wr;
    desc_rd_t            desc_rd;
    logic [7:0]          byte_rdata;
    desc_t               desc_rdata;

    function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  cap);
        logic [CNT_W-1:0] n;
        n = CNT_W'(idx) + CNT_W'(1);
        return (n >= cap) ? '0 : n[SLOT_W-1:0];
    endfunction

    function automatic logic [DROP_W-1:0] sat_inc(input logic [DROP_W-1:0] v);
        return (v == DROP_MAX) ? v : v + DROP_W'(1);
    endfunction

    bmrq_store u_store (
        .clk        (clk),
        .byte_wr    (byte_wr),
        .byte_rd    (byte_rd),
        .byte_rdata (byte_rdata),
        .desc_wr    (desc_wr),
        .desc_rd    (desc_rd),
        .desc_rdata (desc_rdata)
    );

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(RING_SLOTS);
            lim_reg <= LEN_W'(MAX_PAYLOAD);
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_CAPACITY: cap_reg <= pwdata[CNT_W-1:0];
                REG_LIMIT:    lim_reg <= pwdata[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_CAPACITY: prdata = PDATA_W'(cap_reg);
            REG_LIMIT:    prdata = PDATA_W'(lim_reg);
            default:      prdata = '0;
        endcase
    end

    assign eff_cap = (cap_reg == '0) ? CNT_W'(1) :
                     (cap_reg > CNT_W'(RING_SLOTS)) ? CNT_W'(RING_SLOTS) : cap_reg;
    assign eff_lim = (lim_reg < LEN_W'(MIN_PAYLOAD)) ? LEN_W'(MIN_PAYLOAD) :
                     (lim_reg > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : lim_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_xfer  = in_valid && in_ready;

    assign full_now = held_count_reg >= eff_cap;
    assign new_len  = (inc_len_reg != LEN_MAX) ? inc_len_reg + LEN_W'(1) : LEN_MAX;
    assign desc_len = (desc_rdata.len > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) :
                      (desc_rdata.len == '0) ? LEN_W'(1) : desc_rdata.len;
    assign k_plus   = k_reg + LEN_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        read_index_next  = read_index_reg;
        write_index_next = write_index_reg;
        held_count_next  = held_count_reg;
        inc_len_next     = inc_len_reg;
        blocked_next     = blocked_reg;
        full_cnt_next    = full_cnt_reg;
        over_cnt_next    = over_cnt_reg;
        short_cnt_next   = short_cnt_reg;
        pop_slot_next    = pop_slot_reg;
        pop_len_next     = pop_len_reg;
        pop_bid_next     = pop_bid_reg;
        k_next           = k_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_byte_next    = out_byte_reg;
        out_bid_next     = out_bid_reg;
        out_last_next    = out_last_reg;

        byte_wr          = '0;
        byte_rd          = '0;
        desc_wr          = '0;
        desc_rd          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (func_t'(func) == FUNC_PUSH))
                begin
                    // While the ring is full the write slot still belongs to the oldest message.
                    byte_wr.we   = !full_now && (inc_len_reg < eff_lim);
                    byte_wr.addr = {write_index_reg, inc_len_reg[BYTE_IDX_W-1:0]};
                    byte_wr.data = data_byte;
                    inc_len_next = new_len;
                    blocked_next = blocked_reg || full_now;
                    if (last_byte)
                    begin
                        if (new_len > eff_lim)
                        begin
                            over_cnt_next   = sat_inc(over_cnt_reg);
                            out_status_next = ST_OVERSIZE;
                        end
                        else if (new_len < LEN_W'(MIN_PAYLOAD))
                        begin
                            short_cnt_next  = sat_inc(short_cnt_reg);
                            out_status_next = ST_SHORT;
                        end
                        else if (blocked_reg || full_now)
                        begin
                            full_cnt_next   = sat_inc(full_cnt_reg);
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            desc_wr.we       = 1'b1;
                            desc_wr.addr     = write_index_reg;
                            desc_wr.data.len = new_len;
                            desc_wr.data.bid = bid_amount;
                            write_index_next = advance(write_index_reg, eff_cap);
                            held_count_next  = held_count_reg + CNT_W'(1);
                            out_status_next  = ST_PUSHED;
                        end
                        inc_len_next   = '0;
                        blocked_next   = 1'b0;
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        out_bid_next   = '0;
                        out_last_next  = 1'b1;
                    end
                end
                else if (in_xfer)
                begin
                    if (held_count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_EMPTY;
                        out_byte_next   = '0;
                        out_bid_next    = '0;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        desc_rd.re      = 1'b1;
                        desc_rd.addr    = read_index_reg;
                        pop_slot_next   = read_index_reg;
                        read_index_next = advance(read_index_reg, eff_cap);
                        held_count_next = held_count_reg - CNT_W'(1);
                        state_next      = S_POP_DESC;
                    end
                end
            end

            S_POP_DESC:
            begin
                pop_len_next = desc_len;
                pop_bid_next = desc_rdata.bid;
                k_next       = '0;
                byte_rd.re   = 1'b1;
                byte_rd.addr = {pop_slot_reg, {BYTE_IDX_W{1'b0}}};
                state_next   = S_POP_EMIT;
            end

            S_POP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_POPPED;
                    out_byte_next   = byte_rdata;
                    out_bid_next    = pop_bid_reg;
                    out_last_next   = (k_plus == pop_len_reg);
                    if (k_plus == pop_len_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next       = k_plus;
                        byte_rd.re   = 1'b1;
                        byte_rd.addr = {pop_slot_reg, k_plus[BYTE_IDX_W-1:0]};
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            read_index_reg  <= '0;
            write_index_reg <= '0;
            held_count_reg  <= '0;
            inc_len_reg     <= '0;
            blocked_reg     <= 1'b0;
            full_cnt_reg    <= '0;
            over_cnt_reg    <= '0;
            short_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
            k_reg           <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            read_index_reg  <= read_index_next;
            write_index_reg <= write_index_next;
            held_count_reg  <= held_count_next;
            inc_len_reg     <= inc_len_next;
            blocked_reg     <= blocked_next;
            full_cnt_reg    <= full_cnt_next;
            over_cnt_reg    <= over_cnt_next;
            short_cnt_reg   <= short_cnt_next;
            out_valid_reg   <= out_valid_next;
            k_reg           <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_slot_reg   <= pop_slot_next;
        pop_len_reg    <= pop_len_next;
        pop_bid_reg    <= pop_bid_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_bid_reg    <= out_bid_next;
        out_last_reg   <= out_last_next;
    end

    // Occupancy and drop counters change only when input is taken, which needs
    // the output register free, so they can be shown straight from the state registers.
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign out_byte       = out_byte_reg;
    assign out_bid        = out_bid_reg;
    assign out_last       = out_last_reg;
    assign occupancy      = held_count_reg;
    assign full_drops     = full_cnt_reg;
    assign oversize_drops = over_cnt_reg;
    assign short_drops    = short_cnt_reg;

    `BMRQ_ASSERT_NEVER(a_held_bound, held_count_reg > CNT_W'(RING_SLOTS))
    `BMRQ_ASSERT_IMPL(a_byte_wr_idle, byte_wr.we, state_reg == S_IDLE)
    `BMRQ_ASSERT_NEXT(a_pop_starts,
        in_xfer && (func_t'(func) == FUNC_POP) && (held_count_reg != '0),
        state_reg == S_POP_DESC)
    `BMRQ_ASSERT_IMPL(a_last_pop_idle,
        out_valid_reg && out_last_reg && (out_status_reg == ST_POPPED),
        state_reg == S_IDLE)

endmodule

`default_nettype wire
